@@ rtl/acd_pkg.sv @@
// Shared types, constants and the altitude mark table for the callout detector.
package acd_pkg;

  localparam int unsigned AltW     = 25;
  localparam int unsigned CmpW     = 26;
  localparam int unsigned SpeedW   = 18;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgAltW  = 24;
  localparam int unsigned GapW     = 16;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned KindW    = 2;
  localparam int unsigned MarkW    = 13;
  localparam int unsigned MarkCount = 30;
  localparam int unsigned FracW    = 4;

  localparam logic [CfgIdxW-1:0] CfgGearAlt  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClearAlt = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGap      = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgGearPres = 2'd3;

  localparam logic [CfgAltW-1:0] GearAltReset  = 24'd4400;
  localparam logic [CfgAltW-1:0] ClearAltReset = 24'd24000;
  localparam logic [GapW-1:0]    GapReset      = 16'd2000;

  localparam logic signed [SpeedW-1:0] GearRateLimit  = -18'sd4;
  localparam logic signed [SpeedW-1:0] ClearRateLimit = -18'sd2400;

  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 2'd0,
    KIND_GEAR  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_MARK  = 2'd3
  } acd_kind_e;

  typedef struct packed {
    logic signed [AltW-1:0]   altitude;
    logic signed [SpeedW-1:0] vertical_speed;
    logic                     ground_contact;
    logic                     gear_down;
    logic [TimeW-1:0]         sim_time_ms;
  } acd_sample_t;

  typedef struct packed {
    logic [CfgAltW-1:0] gear_warning_altitude;
    logic [CfgAltW-1:0] clearance_altitude;
    logic [GapW-1:0]    callout_gap_ms;
    logic               gear_present;
  } acd_cfg_t;

  typedef struct packed {
    acd_kind_e        kind;
    logic [MarkW-1:0] mark;
    logic             arm_holdoff;
  } acd_decision_t;

  function automatic logic [MarkW-1:0] mark_value(input logic [4:0] idx);
    logic [MarkW-1:0] v;
    case (idx)
      5'd0:    v = 13'd5000;
      5'd1:    v = 13'd4000;
      5'd2:    v = 13'd3000;
      5'd3:    v = 13'd2000;
      5'd4:    v = 13'd1000;
      5'd5:    v = 13'd900;
      5'd6:    v = 13'd800;
      5'd7:    v = 13'd700;
      5'd8:    v = 13'd600;
      5'd9:    v = 13'd500;
      5'd10:   v = 13'd400;
      5'd11:   v = 13'd300;
      5'd12:   v = 13'd200;
      5'd13:   v = 13'd100;
      5'd14:   v = 13'd75;
      5'd15:   v = 13'd50;
      5'd16:   v = 13'd40;
      5'd17:   v = 13'd30;
      5'd18:   v = 13'd20;
      5'd19:   v = 13'd15;
      5'd20:   v = 13'd10;
      5'd21:   v = 13'd9;
      5'd22:   v = 13'd8;
      5'd23:   v = 13'd7;
      5'd24:   v = 13'd6;
      5'd25:   v = 13'd5;
      5'd26:   v = 13'd4;
      5'd27:   v = 13'd3;
      5'd28:   v = 13'd2;
      5'd29:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/acd_eval.sv @@
// Event decision for one registered sample against the previous altitude.
module acd_eval (
  input  acd_pkg::acd_sample_t            sample_i,
  input  acd_pkg::acd_cfg_t               cfg_i,
  input  logic signed [acd_pkg::AltW-1:0] prev_alt_i,
  input  logic [acd_pkg::TimeW-1:0]       holdoff_i,
  output acd_pkg::acd_decision_t          decision_o
);

  logic signed [acd_pkg::CmpW-1:0]   alt;
  logic signed [acd_pkg::CmpW-1:0]   prev;
  logic signed [acd_pkg::CmpW-1:0]   gwa;
  logic signed [acd_pkg::CmpW-1:0]   ca;
  logic signed [acd_pkg::SpeedW-1:0] rate;
  logic                              gear_warn;
  logic                              clear_cross;
  logic                              time_ok;
  logic [acd_pkg::MarkCount-1:0]     hit;
  logic                              any_hit;
  logic [acd_pkg::MarkW-1:0]         hit_mark;
  logic signed [acd_pkg::CmpW-1:0]   level [acd_pkg::MarkCount];

  assign alt  = acd_pkg::CmpW'(sample_i.altitude);
  assign prev = acd_pkg::CmpW'(prev_alt_i);
  assign gwa  = $signed({2'b00, cfg_i.gear_warning_altitude});
  assign ca   = $signed({2'b00, cfg_i.clearance_altitude});
  assign rate = sample_i.ground_contact ? '0 : sample_i.vertical_speed;

  assign gear_warn = cfg_i.gear_present && (alt < prev) && (alt < gwa) &&
                     !sample_i.gear_down && (rate <= acd_pkg::GearRateLimit) &&
                     (alt > 0);
  assign clear_cross = (prev > ca) && (alt <= ca);
  assign time_ok     = sample_i.sim_time_ms >= holdoff_i;

  always_comb begin
    hit_mark = '0;
    for (int i = 0; i < acd_pkg::MarkCount; i++) begin
      level[i] = $signed({{(acd_pkg::CmpW - acd_pkg::MarkW - acd_pkg::FracW){1'b0}},
                          acd_pkg::mark_value(5'(i)), {acd_pkg::FracW{1'b0}}});
      hit[i]   = (prev > level[i]) && (alt <= level[i]);
    end
    for (int i = acd_pkg::MarkCount - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_mark = acd_pkg::mark_value(5'(i));
      end
    end
  end

  assign any_hit = |hit;

  always_comb begin
    decision_o.kind        = acd_pkg::KIND_NONE;
    decision_o.mark        = '0;
    decision_o.arm_holdoff = 1'b0;
    if (!prev_alt_i[acd_pkg::AltW-1]) begin
      if (gear_warn) begin
        decision_o.kind = acd_pkg::KIND_GEAR;
      end else if (time_ok) begin
        if (clear_cross) begin
          if (rate > acd_pkg::ClearRateLimit) begin
            decision_o.kind        = acd_pkg::KIND_CLEAR;
            decision_o.arm_holdoff = 1'b1;
          end
        end else if (any_hit) begin
          decision_o.kind        = acd_pkg::KIND_MARK;
          decision_o.mark        = hit_mark;
          decision_o.arm_holdoff = 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/altitude_callout_detector.sv @@
// Top level of the altitude callout detector: sample register, state, result register.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i/in_stall_o    altitude, vertical_speed, ground_contact,
//                                                 gear_down, sim_time_ms
//   out       source     out_valid_o/out_stall_i  event_kind, mark_metres
//   cfg       sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One transaction per cycle while the output is not stalled; a sample's event passes from the
// sample register through the decision logic into the result register, which drives the outputs.
// Reset clears the previous altitude to no-sample, the hold-off to zero, the configuration
// registers to their defaults and the valid flags. A stalled output holds its event; the sample
// register keeps accepting while the result register can drain.
module altitude_callout_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [acd_pkg::AltW-1:0]      altitude_i,
  input  logic signed [acd_pkg::SpeedW-1:0]    vertical_speed_i,
  input  logic                                 ground_contact_i,
  input  logic                                 gear_down_i,
  input  logic [acd_pkg::TimeW-1:0]            sim_time_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [acd_pkg::KindW-1:0]            event_kind_o,
  output logic [acd_pkg::MarkW-1:0]            mark_metres_o,
  input  logic                                 cfg_we_i,
  input  logic [acd_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [acd_pkg::CfgDataW-1:0]         cfg_data_i
);

  acd_pkg::acd_cfg_t               cfg_q;
  acd_pkg::acd_sample_t            sample_q;
  logic                            sample_valid_q;
  logic signed [acd_pkg::AltW-1:0] prev_alt_q;
  logic [acd_pkg::TimeW-1:0]       holdoff_q;
  logic [acd_pkg::TimeW-1:0]       holdoff_d;
  logic [acd_pkg::TimeW:0]         holdoff_sum;
  acd_pkg::acd_decision_t          decision;
  logic                            out_valid_q;
  acd_pkg::acd_kind_e              kind_q;
  logic [acd_pkg::MarkW-1:0]       mark_q;
  logic                            out_free;
  logic                            advance;
  logic                            accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = sample_valid_q && out_free;
  assign in_stall_o = sample_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gear_warning_altitude <= acd_pkg::GearAltReset;
      cfg_q.clearance_altitude    <= acd_pkg::ClearAltReset;
      cfg_q.callout_gap_ms        <= acd_pkg::GapReset;
      cfg_q.gear_present          <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        acd_pkg::CfgGearAlt:  cfg_q.gear_warning_altitude <= cfg_data_i;
        acd_pkg::CfgClearAlt: cfg_q.clearance_altitude    <= cfg_data_i;
        acd_pkg::CfgGap:      cfg_q.callout_gap_ms        <= cfg_data_i[acd_pkg::GapW-1:0];
        acd_pkg::CfgGearPres: cfg_q.gear_present          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_valid_q <= 1'b0;
    end else if (accept) begin
      sample_valid_q <= 1'b1;
    end else if (advance) begin
      sample_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q.altitude       <= altitude_i;
      sample_q.vertical_speed <= vertical_speed_i;
      sample_q.ground_contact <= ground_contact_i;
      sample_q.gear_down      <= gear_down_i;
      sample_q.sim_time_ms    <= sim_time_ms_i;
    end
  end

  acd_eval u_eval (
    .sample_i   (sample_q),
    .cfg_i      (cfg_q),
    .prev_alt_i (prev_alt_q),
    .holdoff_i  (holdoff_q),
    .decision_o (decision)
  );

  assign holdoff_sum = {1'b0, sample_q.sim_time_ms} +
                       {{(acd_pkg::TimeW + 1 - acd_pkg::GapW){1'b0}}, cfg_q.callout_gap_ms};
  assign holdoff_d   = holdoff_sum[acd_pkg::TimeW] ? '1 : holdoff_sum[acd_pkg::TimeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_alt_q <= '1;
      holdoff_q  <= '0;
    end else if (advance) begin
      prev_alt_q <= sample_q.altitude;
      if (decision.arm_holdoff) begin
        holdoff_q <= holdoff_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= decision.kind;
      mark_q <= decision.mark;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign mark_metres_o = mark_q;

endmodule

@@ rtl/acd_checker.sv @@
// Port-level assertions for the altitude callout detector, bound to the top level.
module acd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [acd_pkg::KindW-1:0]   event_kind_o,
  input logic [acd_pkg::MarkW-1:0]   mark_metres_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o) &&
    $stable(mark_metres_o))
    else $error("stalled output transaction changed");

  a_mark_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != acd_pkg::KIND_MARK) |-> mark_metres_o == '0)
    else $error("mark set on a non-mark event");

  a_mark_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == acd_pkg::KIND_MARK) |->
    (mark_metres_o != '0) && (mark_metres_o <= 13'd5000))
    else $error("mark event without a valid mark");

  a_no_stall_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

bind altitude_callout_detector acd_checker u_acd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .event_kind_o  (event_kind_o),
  .mark_metres_o (mark_metres_o)
);
